// ===== rtl/hetc_pkg.sv =====
`default_nettype none
package hetc_pkg;

	localparam int MAX_COMMANDS = 256;
	localparam int ANGLE_BITS = 12;
	localparam int ANGLE_STEPS = 1 << ANGLE_BITS;
	localparam int FRAC_BITS = 12;
	localparam int SC_W = FRAC_BITS + 2;

	localparam logic [16:0] SIN_A = 17'd102873;
	localparam logic [16:0] SIN_B = 17'd41906;
	localparam logic [16:0] SIN_C = 17'd4569;

	localparam logic OPC_NODE = 1'b0;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT,
		OP_SINE,
		OP_ROT,
		OP_NODE,
		OP_LOADP,
		OP_COMP,
		OP_ANC,
		OP_COMMIT,
		OP_EMIT,
		OP_EMIT_BAD
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_INIT,
		ST_SINE,
		ST_ROT,
		ST_NODE,
		ST_LOADP,
		ST_COMP,
		ST_ANC,
		ST_COMMIT,
		ST_EMIT,
		ST_EMIT_BAD
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
		logic       fn;
		logic [1:0] row;
		logic [1:0] col;
		logic [3:0] cnt;
		logic [1:0] mterm;
		logic       mul_en;
		logic [1:0] aterm;
		logic       acc_en;
		logic       acc_first;
		logic       wb_en;
		logic       take;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic is_node;
		logic ovf;
		logic bad;
		logic out_free;
	} stat_t;

	function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
		idx3 = 4'({r, 1'b0}) + 4'(r) + 4'(c);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [37:0] x);
		if (x > 38'sd32767)
			sat16 = 16'sh7fff;
		else if (x < -38'sd32768)
			sat16 = 16'sh8000;
		else
			sat16 = 16'(x);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
		if (x > 38'sd2147483647)
			sat32 = 32'sh7fffffff;
		else if (x < -38'sd2147483648)
			sat32 = 32'sh80000000;
		else
			sat32 = 32'(x);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/hierarchical_euler_transform_compose.sv =====
`default_nettype none
// Channel   Handshake                 Payload
// item      item_valid / item_stall   opcode, angle_x..z, pos_x..z, parent_index
// result    res_valid / res_stall     cmd_index, row_index, m_col0..2, trans, ok, last
//
// One item is processed at a time; item_stall stays high until the command finishes. Work runs on
// the single shared 18x18 multiplier: sine polynomials, rotations, matrix product and anchor.
// A node item skips the product and anchor; a rejected or overflowed command emits one row.
// Reset leaves the node matrix at identity and clears all command marks at once.
// A stalled result holds the last row; the next item is taken once that row is loaded.
module hierarchical_euler_transform_compose #(
	parameter int MAX_COMMANDS = hetc_pkg::MAX_COMMANDS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic               opcode,
	input  wire logic signed [15:0] angle_x,
	input  wire logic signed [15:0] angle_y,
	input  wire logic signed [15:0] angle_z,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] pos_z,
	input  wire logic signed [8:0]  parent_index,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [7:0]              cmd_index,
	output logic [1:0]              row_index,
	output logic signed [15:0]      m_col0,
	output logic signed [15:0]      m_col1,
	output logic signed [15:0]      m_col2,
	output logic signed [31:0]      trans,
	output logic                    ok,
	output logic                    last
);

	hetc_pkg::cmd_t  cmd;
	hetc_pkg::stat_t stat;

	hetc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	hetc_dp #(
		.MAX_COMMANDS (MAX_COMMANDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (opcode),
		.angle_x      (angle_x),
		.angle_y      (angle_y),
		.angle_z      (angle_z),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.parent_index (parent_index),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.cmd_index    (cmd_index),
		.row_index    (row_index),
		.m_col0       (m_col0),
		.m_col1       (m_col1),
		.m_col2       (m_col2),
		.trans        (trans),
		.ok           (ok),
		.last         (last)
	);

endmodule
`default_nettype wire

// ===== rtl/hetc_ctrl.sv =====
`default_nettype none
module hetc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire hetc_pkg::stat_t stat,
	output hetc_pkg::cmd_t       cmd
);

	hetc_pkg::state_t state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic       fn_q, fn_d;
	logic [1:0] row_q, row_d;
	logic [1:0] col_q, col_d;
	logic [3:0] cnt_q, cnt_d;
	logic [2:0] st_q, st_d;
	logic [2:0] nterms;
	logic       task_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hetc_pkg::ST_IDLE;
			axis_q  <= '0;
			fn_q    <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
			cnt_q   <= '0;
			st_q    <= '0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			fn_q    <= fn_d;
			row_q   <= row_d;
			col_q   <= col_d;
			cnt_q   <= cnt_d;
			st_q    <= st_d;
		end
	end

	always_comb begin
		state_d = state_q;
		axis_d  = axis_q;
		fn_d    = fn_q;
		row_d   = row_q;
		col_d   = col_q;
		cnt_d   = cnt_q;
		st_d    = st_q;
		item_stall = (state_q != hetc_pkg::ST_IDLE);

		case (state_q)
			hetc_pkg::ST_SINE: nterms = 3'd1;
			hetc_pkg::ST_ROT:  nterms = 3'd2;
			hetc_pkg::ST_COMP: nterms = 3'd3;
			hetc_pkg::ST_ANC:  nterms = 3'd3;
			default:           nterms = 3'd0;
		endcase

		cmd           = '0;
		cmd.op        = hetc_pkg::OP_NONE;
		cmd.axis      = axis_q;
		cmd.fn        = fn_q;
		cmd.row       = row_q;
		cmd.col       = col_q;
		cmd.cnt       = cnt_q;
		cmd.mterm     = st_q[1:0];
		cmd.mul_en    = (nterms != 3'd0) && (st_q < nterms);
		cmd.aterm     = 2'(st_q - 3'd1);
		cmd.acc_en    = (nterms != 3'd0) && (st_q >= 3'd1) && (st_q <= nterms);
		cmd.acc_first = (st_q == 3'd1);
		cmd.wb_en     = (nterms != 3'd0) && (st_q == nterms + 3'd1);
		task_done     = cmd.wb_en;
		if (nterms != 3'd0)
			st_d = task_done ? 3'd0 : st_q + 3'd1;

		case (state_q)
			hetc_pkg::ST_IDLE: begin
				cmd.take = item_valid;
				if (item_valid)
					state_d = hetc_pkg::ST_DECIDE;
			end
			hetc_pkg::ST_DECIDE: begin
				if (!stat.is_node && (stat.ovf || stat.bad))
					state_d = hetc_pkg::ST_EMIT_BAD;
				else
					state_d = hetc_pkg::ST_INIT;
			end
			hetc_pkg::ST_INIT: begin
				cmd.op  = hetc_pkg::OP_INIT;
				state_d = hetc_pkg::ST_SINE;
				axis_d  = '0;
				fn_d    = 1'b0;
				row_d   = '0;
				col_d   = '0;
				st_d    = '0;
			end
			hetc_pkg::ST_SINE: begin
				cmd.op = hetc_pkg::OP_SINE;
				if (task_done) begin
					if (col_q == 2'd3) begin
						col_d = '0;
						if (!fn_q) begin
							fn_d = 1'b1;
						end else begin
							fn_d    = 1'b0;
							row_d   = '0;
							state_d = hetc_pkg::ST_ROT;
						end
					end else begin
						col_d = col_q + 2'd1;
					end
				end
			end
			hetc_pkg::ST_ROT: begin
				cmd.op = hetc_pkg::OP_ROT;
				if (task_done) begin
					if (row_q == 2'd0) begin
						row_d = 2'd1;
					end else begin
						row_d = '0;
						if (col_q == 2'd2) begin
							col_d = '0;
							if (axis_q == 2'd2) begin
								cnt_d   = '0;
								state_d = stat.is_node ? hetc_pkg::ST_NODE
								                       : hetc_pkg::ST_LOADP;
							end else begin
								axis_d  = axis_q + 2'd1;
								state_d = hetc_pkg::ST_SINE;
							end
						end else begin
							col_d = col_q + 2'd1;
						end
					end
				end
			end
			hetc_pkg::ST_NODE: begin
				cmd.op  = hetc_pkg::OP_NODE;
				state_d = hetc_pkg::ST_IDLE;
			end
			hetc_pkg::ST_LOADP: begin
				cmd.op = hetc_pkg::OP_LOADP;
				if (cnt_q == 4'd9) begin
					cnt_d   = '0;
					row_d   = '0;
					col_d   = '0;
					state_d = hetc_pkg::ST_COMP;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			hetc_pkg::ST_COMP: begin
				cmd.op = hetc_pkg::OP_COMP;
				if (task_done) begin
					if (col_q == 2'd2) begin
						col_d = '0;
						if (row_q == 2'd2) begin
							row_d   = '0;
							state_d = hetc_pkg::ST_ANC;
						end else begin
							row_d = row_q + 2'd1;
						end
					end else begin
						col_d = col_q + 2'd1;
					end
				end
			end
			hetc_pkg::ST_ANC: begin
				cmd.op = hetc_pkg::OP_ANC;
				if (task_done) begin
					if (row_q == 2'd2) begin
						row_d   = '0;
						state_d = hetc_pkg::ST_COMMIT;
					end else begin
						row_d = row_q + 2'd1;
					end
				end
			end
			hetc_pkg::ST_COMMIT: begin
				cmd.op  = hetc_pkg::OP_COMMIT;
				row_d   = '0;
				state_d = hetc_pkg::ST_EMIT;
			end
			hetc_pkg::ST_EMIT: begin
				cmd.op = hetc_pkg::OP_EMIT;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (row_q == 2'd2) begin
						row_d   = '0;
						state_d = hetc_pkg::ST_IDLE;
					end else begin
						row_d = row_q + 2'd1;
					end
				end
			end
			hetc_pkg::ST_EMIT_BAD: begin
				cmd.op = hetc_pkg::OP_EMIT_BAD;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = hetc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hetc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/hetc_dp.sv =====
`default_nettype none
module hetc_dp #(
	parameter int MAX_COMMANDS = hetc_pkg::MAX_COMMANDS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hetc_pkg::cmd_t     cmd,
	output hetc_pkg::stat_t         stat,
	input  wire logic               opcode,
	input  wire logic signed [15:0] angle_x,
	input  wire logic signed [15:0] angle_y,
	input  wire logic signed [15:0] angle_z,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] pos_z,
	input  wire logic signed [8:0]  parent_index,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [7:0]              cmd_index,
	output logic [1:0]              row_index,
	output logic signed [15:0]      m_col0,
	output logic signed [15:0]      m_col1,
	output logic signed [15:0]      m_col2,
	output logic signed [31:0]      trans,
	output logic                    ok,
	output logic                    last
);

	localparam int CW  = $clog2(MAX_COMMANDS + 1);
	localparam int IW  = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
	localparam int MAW = $clog2(MAX_COMMANDS * 9);
	localparam int TAW = $clog2(MAX_COMMANDS * 3);
	localparam int F   = hetc_pkg::FRAC_BITS;
	localparam int SCW = hetc_pkg::SC_W;
	localparam int AB  = hetc_pkg::ANGLE_BITS;

	logic                   opc_q;
	logic signed [15:0]     ang_q [3];
	logic signed [15:0]     pos_q [3];
	logic signed [8:0]      par_q;
	logic [CW-1:0]          cur_idx_q;

	logic [CW-1:0]          counter_q;
	logic [MAX_COMMANDS-1:0] marks_q;
	logic signed [15:0]     nm_q [9];
	logic signed [31:0]     nt_q [3];

	logic signed [15:0]     w_q [9];
	logic signed [15:0]     pm_q [9];
	logic signed [31:0]     pt_q [3];
	logic signed [15:0]     r_q [9];
	logic signed [31:0]     rt_q [3];
	logic signed [15:0]     tmp_q;
	logic signed [SCW-1:0]  s_q, c_q;
	logic [16:0]            z2_q, t_q;

	logic signed [17:0]     mul_a, mul_b;
	logic signed [35:0]     prod_q;
	logic signed [37:0]     acc_q;

	logic signed [15:0]     mat_mem [MAX_COMMANDS * 9];
	logic signed [31:0]     tr_mem [MAX_COMMANDS * 3];
	logic signed [15:0]     mat_rd_q;
	logic signed [31:0]     tr_rd_q;

	logic [AB-1:0]          ph;
	logic [1:0]             qf;
	logic [16:0]            zpos, zz;
	logic [1:0]             ra, rb;
	logic                   use_s;
	logic signed [15:0]     res16;
	logic signed [31:0]     sum32;
	logic [16:0]            v17;
	logic [17:0]            rnd;
	logic signed [SCW-1:0]  mag, sval;
	logic                   neg;
	logic                   par_node;
	logic [3:0]             e_rc;
	logic [MAW-1:0]         mat_waddr, mat_raddr;
	logic [TAW-1:0]         tr_waddr, tr_raddr;
	logic                   mat_we, tr_we;
	logic                   acc_sub;
	logic signed [37:0]     prod_x;

	assign par_node = (par_q == -9'sd1);
	assign stat.is_node = (opc_q == hetc_pkg::OPC_NODE);
	assign stat.ovf = (counter_q >= CW'(MAX_COMMANDS));
	assign stat.bad = !par_node && (par_q[8] || (10'(par_q[7:0]) >= 10'(counter_q)) ||
	                  !marks_q[par_q[IW-1:0]]);
	assign stat.out_free = !res_valid || !res_stall;

	always_comb begin
		case (cmd.axis)
			2'd0:    ph = ang_q[0][AB-1:0];
			2'd1:    ph = ang_q[1][AB-1:0];
			default: ph = ang_q[2][AB-1:0];
		endcase
		qf   = ph[AB-1:AB-2] + {1'b0, cmd.fn};
		zpos = 17'(ph[AB-3:0]) << (18 - AB);
		zz   = qf[0] ? (17'd65536 - zpos) : zpos;
		case (cmd.axis)
			2'd0:    begin ra = 2'd1; rb = 2'd2; end
			2'd1:    begin ra = 2'd0; rb = 2'd2; end
			default: begin ra = 2'd0; rb = 2'd1; end
		endcase
		use_s = (cmd.mterm == 2'd0) ? cmd.row[0] : !cmd.row[0];
		e_rc  = hetc_pkg::idx3(cmd.row, cmd.col);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			hetc_pkg::OP_SINE: begin
				case (cmd.col)
					2'd0: begin
						mul_a = 18'(zz);
						mul_b = 18'(zz);
					end
					2'd1: begin
						mul_a = 18'(hetc_pkg::SIN_C);
						mul_b = 18'(z2_q);
					end
					2'd2: begin
						mul_a = 18'(hetc_pkg::SIN_B - t_q);
						mul_b = 18'(z2_q);
					end
					default: begin
						mul_a = 18'(zz);
						mul_b = 18'(hetc_pkg::SIN_A - t_q);
					end
				endcase
			end
			hetc_pkg::OP_ROT: begin
				mul_a = use_s ? 18'(s_q) : 18'(c_q);
				mul_b = 18'(w_q[hetc_pkg::idx3((cmd.mterm == 2'd0) ? ra : rb, cmd.col)]);
			end
			hetc_pkg::OP_COMP: begin
				mul_a = 18'(pm_q[hetc_pkg::idx3(cmd.row, cmd.mterm)]);
				mul_b = 18'(w_q[hetc_pkg::idx3(cmd.mterm, cmd.col)]);
			end
			hetc_pkg::OP_ANC: begin
				mul_a = 18'(pm_q[hetc_pkg::idx3(cmd.row, cmd.mterm)]);
				case (cmd.mterm)
					2'd0:    mul_b = 18'(pos_q[0]);
					2'd1:    mul_b = 18'(pos_q[1]);
					default: mul_b = 18'(pos_q[2]);
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		res16 = hetc_pkg::sat16(acc_q >>> F);
		sum32 = hetc_pkg::sat32((acc_q >>> F) + 38'(pt_q[cmd.row]));
		v17   = 17'(acc_q >>> 16);
		rnd   = (18'(v17) + 18'(1 << (15 - F))) >> (16 - F);
		mag   = SCW'(rnd);
		neg   = qf[1] ^ (!cmd.fn && (cmd.axis == 2'd1));
		sval  = neg ? -mag : mag;
		acc_sub = (cmd.op == hetc_pkg::OP_ROT) && !cmd.row[0] && (cmd.aterm == 2'd1);
		prod_x  = 38'(prod_q);
		mat_we    = cmd.wb_en && (cmd.op == hetc_pkg::OP_COMP);
		tr_we     = cmd.wb_en && (cmd.op == hetc_pkg::OP_ANC);
		mat_waddr = MAW'(32'(cur_idx_q) * 32'd9 + 32'(e_rc));
		tr_waddr  = TAW'(32'(cur_idx_q) * 32'd3 + 32'(cmd.row));
		mat_raddr = MAW'(32'(par_q[7:0]) * 32'd9 + 32'(cmd.cnt));
		tr_raddr  = TAW'(32'(par_q[7:0]) * 32'd3 + 32'(cmd.cnt[1:0]));
	end

	always_ff @(posedge clk) begin
		if (mat_we)
			mat_mem[mat_waddr] <= res16;
		if (tr_we)
			tr_mem[tr_waddr] <= sum32;
		mat_rd_q <= mat_mem[mat_raddr];
		tr_rd_q  <= tr_mem[tr_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			marks_q   <= '0;
			res_valid <= 1'b0;
			for (int i = 0; i < 9; i++)
				nm_q[i] <= (i % 4 == 0) ? 16'(1 << F) : 16'sd0;
			for (int i = 0; i < 3; i++)
				nt_q[i] <= '0;
		end else begin
			if (cmd.out_load)
				res_valid <= 1'b1;
			else if (!res_stall)
				res_valid <= 1'b0;
			if (cmd.op == hetc_pkg::OP_NODE) begin
				for (int i = 0; i < 9; i++)
					nm_q[i] <= w_q[i];
				for (int i = 0; i < 3; i++)
					nt_q[i] <= 32'(pos_q[i]);
				marks_q   <= '0;
				counter_q <= '0;
			end
			if (cmd.op == hetc_pkg::OP_COMMIT) begin
				marks_q[cur_idx_q[IW-1:0]] <= 1'b1;
				counter_q <= counter_q + CW'(1);
			end
			if (cmd.out_load && (cmd.op == hetc_pkg::OP_EMIT_BAD) && !stat.ovf) begin
				marks_q[cur_idx_q[IW-1:0]] <= 1'b0;
				counter_q <= counter_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			opc_q     <= opcode;
			ang_q[0]  <= angle_x;
			ang_q[1]  <= angle_y;
			ang_q[2]  <= angle_z;
			pos_q[0]  <= pos_x;
			pos_q[1]  <= pos_y;
			pos_q[2]  <= pos_z;
			par_q     <= parent_index;
			cur_idx_q <= counter_q;
		end
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		if (cmd.acc_en) begin
			if (cmd.acc_first)
				acc_q <= acc_sub ? -prod_x : prod_x;
			else
				acc_q <= acc_sub ? acc_q - prod_x : acc_q + prod_x;
		end
		if (cmd.op == hetc_pkg::OP_INIT) begin
			for (int i = 0; i < 9; i++)
				w_q[i] <= (i % 4 == 0) ? 16'(1 << F) : 16'sd0;
		end
		if (cmd.wb_en) begin
			case (cmd.op)
				hetc_pkg::OP_SINE: begin
					case (cmd.col)
						2'd0: z2_q <= v17;
						2'd1: t_q  <= v17;
						2'd2: t_q  <= v17;
						default: begin
							if (cmd.fn)
								c_q <= sval;
							else
								s_q <= sval;
						end
					endcase
				end
				hetc_pkg::OP_ROT: begin
					if (!cmd.row[0]) begin
						tmp_q <= res16;
					end else begin
						w_q[hetc_pkg::idx3(rb, cmd.col)] <= res16;
						w_q[hetc_pkg::idx3(ra, cmd.col)] <= tmp_q;
					end
				end
				hetc_pkg::OP_COMP: r_q[e_rc] <= res16;
				hetc_pkg::OP_ANC:  rt_q[cmd.row] <= sum32;
				default: begin
				end
			endcase
		end
		if ((cmd.op == hetc_pkg::OP_LOADP) && (cmd.cnt != 4'd0)) begin
			pm_q[cmd.cnt - 4'd1] <= par_node ? nm_q[cmd.cnt - 4'd1] : mat_rd_q;
			if (cmd.cnt <= 4'd3)
				pt_q[2'(cmd.cnt - 4'd1)] <= par_node ? nt_q[2'(cmd.cnt - 4'd1)] : tr_rd_q;
		end
		if (cmd.out_load) begin
			if (cmd.op == hetc_pkg::OP_EMIT) begin
				cmd_index <= 8'(cur_idx_q);
				row_index <= cmd.row;
				m_col0    <= r_q[hetc_pkg::idx3(cmd.row, 2'd0)];
				m_col1    <= r_q[hetc_pkg::idx3(cmd.row, 2'd1)];
				m_col2    <= r_q[hetc_pkg::idx3(cmd.row, 2'd2)];
				trans     <= rt_q[cmd.row];
				ok        <= 1'b1;
				last      <= (cmd.row == 2'd2);
			end else begin
				cmd_index <= stat.ovf ? 8'd0 : 8'(cur_idx_q);
				row_index <= '0;
				m_col0    <= '0;
				m_col1    <= '0;
				m_col2    <= '0;
				trans     <= '0;
				ok        <= 1'b0;
				last      <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire
